// ===== rtl/gmla_pkg.sv =====
package gmla_pkg;

    localparam int LOAD_W = 32;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 5;
    localparam int TASK_W = 16;
    localparam int MID_W  = 4;

    localparam logic [CFG_W-1:0]  NUM_MACHINES_RESET = 5'd4;
    localparam logic [LOAD_W-1:0] LOAD_MAX           = '1;

    typedef struct packed {
        logic [TASK_W-1:0] task_length;
        logic              new_schedule;
    } in_t;

    typedef struct packed {
        logic [MID_W-1:0]  assigned_machine;
        logic [LOAD_W-1:0] machine_load;
        logic [LOAD_W-1:0] makespan;
    } out_t;

endpackage

// ===== rtl/greedy_min_load_assign_top.sv =====
// Greedy minimum-load task assigner (list scheduling in arrival order).
// Input channel s_*: one transaction per task, carrying task_length and
// new_schedule (1 clears all loads, the task count and the makespan first).
// Output channel m_*: one transaction per task with the assigned machine,
// that machine's new load (saturating at all ones) and the running makespan.
// Within a schedule the first tasks go to machines count-1 down to 0; after
// that each task goes to the least loaded active machine, lowest index on tie.
// cfg_wr_en/cfg_wr_data set the machine count (0 acts as 1, values above
// MAX_MACHINES clamp); write it only while no task is in flight.
// The result is registered and valid the cycle after the input is accepted.
// Throughput: one task per cycle while the receiver does not stall. The per-machine loads live in flops and a
// comparator tree over all MAX_MACHINES loads plus the saturating add forms
// the combinational path from the load registers back to themselves.
// A stalled receiver holds the result register; s_ready stays high while the
// result register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) clears all loads, the task count and the
// makespan, sets the machine count to 4 and empties the output register.
module greedy_min_load_assign_top #(
    parameter int MAX_MACHINES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  gmla_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output gmla_pkg::out_t               m_data,
    input  logic                         cfg_wr_en,
    input  logic [gmla_pkg::CFG_W-1:0]   cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_MACHINES);
    localparam int M_CAP = (MAX_MACHINES < 31) ? MAX_MACHINES : 31;
    localparam int LW    = gmla_pkg::LOAD_W;
    localparam int CW    = gmla_pkg::CNT_W;

    logic [LW-1:0]                  loads_reg [MAX_MACHINES];
    logic [CW-1:0]                  tasks_reg, tasks_next;
    logic [LW-1:0]                  mkspan_reg, mkspan_next;
    logic [gmla_pkg::CFG_W-1:0]     nmach_reg;
    logic                           m_valid_reg;
    gmla_pkg::out_t                 out_reg, out_next;

    logic                           accept;
    logic                           start;
    logic [CW-1:0]                  m_cnt;
    logic [CW-1:0]                  tasks_eff;
    logic [LW-1:0]                  mkspan_eff;
    logic                           in_fill;
    logic [CW-1:0]                  fill_pick;
    logic [IDX_W-1:0]               min_idx;
    logic [IDX_W-1:0]               pick;
    logic [31:0]                    pick_ext;
    logic [LW-1:0]                  old_load;
    logic [LW:0]                    sum;
    logic [LW-1:0]                  new_load;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign start   = s_data.new_schedule;

    always_comb begin
        if (nmach_reg == '0) begin
            m_cnt = CW'(1);
        end else if (32'(nmach_reg) > 32'(M_CAP)) begin
            m_cnt = CW'(M_CAP);
        end else begin
            m_cnt = nmach_reg;
        end
    end

    gmla_min_search #(
        .N (MAX_MACHINES)
    ) u_min_search (
        .loads      (loads_reg),
        .active_cnt (m_cnt),
        .min_idx    (min_idx)
    );

    always_comb begin
        tasks_eff  = start ? '0 : tasks_reg;
        mkspan_eff = start ? '0 : mkspan_reg;
        in_fill    = tasks_eff < m_cnt;
        fill_pick  = m_cnt - CW'(1) - tasks_eff;
        pick       = in_fill ? IDX_W'(fill_pick) : min_idx;
        pick_ext   = 32'(pick);
        old_load   = start ? '0 : loads_reg[pick];
        sum        = {1'b0, old_load} + (LW+1)'(s_data.task_length);
        new_load   = sum[LW] ? gmla_pkg::LOAD_MAX : sum[LW-1:0];
        mkspan_next = (new_load > mkspan_eff) ? new_load : mkspan_eff;
        // count only increments while below the active machine count, which is at most 31
        tasks_next = in_fill ? tasks_eff + CW'(1) : tasks_eff;
        out_next.assigned_machine = pick_ext[gmla_pkg::MID_W-1:0];
        out_next.machine_load     = new_load;
        out_next.makespan         = mkspan_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_MACHINES; i++) begin
                loads_reg[i] <= '0;
            end
            tasks_reg   <= '0;
            mkspan_reg  <= '0;
            nmach_reg   <= gmla_pkg::NUM_MACHINES_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                nmach_reg <= cfg_wr_data;
            end
            if (accept) begin
                for (int i = 0; i < MAX_MACHINES; i++) begin
                    if (IDX_W'(i) == pick) begin
                        loads_reg[i] <= new_load;
                    end else if (start) begin
                        loads_reg[i] <= '0;
                    end
                end
                tasks_reg   <= tasks_next;
                mkspan_reg  <= mkspan_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

    // assertions

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted task produced no result");

    a_mkspan_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !start) |=> (mkspan_reg >= $past(mkspan_reg)))
        else $error("makespan decreased within a schedule");

    a_load_le_mkspan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (out_reg.machine_load <= out_reg.makespan))
        else $error("reported load exceeds makespan");

    a_tasks_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(tasks_reg) <= 32'(M_CAP))
        else $error("task count above machine cap");

    a_mkspan_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (mkspan_reg == out_reg.makespan))
        else $error("makespan register and result disagree");

endmodule

// ===== rtl/gmla_min_search.sv =====
module gmla_min_search #(
    parameter int N = 16
) (
    input  logic [gmla_pkg::LOAD_W-1:0] loads [N],
    input  logic [gmla_pkg::CNT_W-1:0]  active_cnt,
    output logic [$clog2(N)-1:0]        min_idx
);

    localparam int IDX_W = $clog2(N);
    localparam int P     = 1 << IDX_W;

    typedef struct packed {
        logic                       vld;
        logic [gmla_pkg::LOAD_W-1:0] load;
        logic [IDX_W-1:0]           idx;
    } node_t;

    node_t nodes [2*P-1];

    // Heap-ordered comparator tree; left child holds lower machine numbers,
    // so ties resolve toward the lowest index.
    always_comb begin
        for (int i = 0; i < P; i++) begin
            nodes[P-1+i].idx = IDX_W'(i);
            if (i < N) begin
                nodes[P-1+i].vld  = (32'(i) < 32'(active_cnt));
                nodes[P-1+i].load = loads[i];
            end else begin
                nodes[P-1+i].vld  = 1'b0;
                nodes[P-1+i].load = '0;
            end
        end
        for (int n = P-2; n >= 0; n--) begin
            if (nodes[2*n+1].vld &&
                (!nodes[2*n+2].vld || nodes[2*n+1].load <= nodes[2*n+2].load)) begin
                nodes[n] = nodes[2*n+1];
            end else begin
                nodes[n] = nodes[2*n+2];
            end
        end
    end

    assign min_idx = nodes[0].idx;

endmodule
